// File: rtl/ookrs_pkg.sv
package ookrs_pkg;

  // Input item kinds: a one-microsecond tick or one of the three commands.
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_GROUP = 2'd1,
    MODE_UNIT  = 2'd2,
    MODE_DIM   = 2'd3
  } mode_t;

  // Line symbols of a frame.
  typedef enum logic [2:0] {
    SYM_START = 3'd0,
    SYM_STOP  = 3'd1,
    SYM_ONE   = 3'd2,
    SYM_ZERO  = 3'd3,
    SYM_DIM   = 3'd4
  } sym_kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_REPEAT  = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 26;
  localparam int PERIOD_W   = 11;
  localparam int REP_EXP_W  = 3;
  localparam int REPEATS_W  = 8;
  // Long enough for a 40T stop gap at the largest period.
  localparam int SEG_LEN_W  = 17;
  // Covers the final symbol index for any address length up to 52 bits.
  localparam int SYM_IDX_W  = 6;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 11'd260;
  localparam logic [REP_EXP_W-1:0] REPEAT_RESET = 3'd2;

  // Latched command and position within the current frame.
  typedef struct packed {
    mode_t                  kind;
    logic                   sw;
    logic [3:0]             unit;
    logic [3:0]             dim;
    logic [SYM_IDX_W-1:0]   sym_idx;
    logic [1:0]             phase;
  } frame_state_t;

  // Decoded view of the segment now on the air.
  typedef struct packed {
    sym_kind_t              sym;
    logic [SEG_LEN_W-1:0]   len;
    logic                   last_seg;
    logic                   last_sym;
  } seg_info_t;

  typedef struct packed {
    logic rf_on;
    logic busy_res;
    logic rejected;
  } result_t;

endpackage

// File: rtl/ookrs_frame_decode.sv
module ookrs_frame_decode #(
  parameter int ADDRESS_BITS = 26
) (
  input  ookrs_pkg::frame_state_t             frame,
  input  logic [ADDRESS_BITS-1:0]             address,
  input  logic [ookrs_pkg::PERIOD_W-1:0]      period,
  output ookrs_pkg::seg_info_t                seg
);
  import ookrs_pkg::*;

  localparam logic [SYM_IDX_W-1:0] ADDR_LAST = SYM_IDX_W'(ADDRESS_BITS);

  logic [SYM_IDX_W-1:0]    last_idx;
  logic [SYM_IDX_W-1:0]    addr_off;
  logic [SYM_IDX_W-1:0]    unit_off;
  logic [SYM_IDX_W-1:0]    dim_off;
  logic [ADDRESS_BITS-1:0] addr_shifted;
  logic [PERIOD_W-1:0]     t;
  logic [SEG_LEN_W-1:0]    t_ext;
  sym_kind_t               sym;

  always_comb begin
    last_idx = ADDR_LAST + ((frame.kind == MODE_DIM) ? SYM_IDX_W'(11) : SYM_IDX_W'(7));
    addr_off = ADDR_LAST - frame.sym_idx;
    unit_off = ADDR_LAST + SYM_IDX_W'(6) - frame.sym_idx;
    dim_off  = ADDR_LAST + SYM_IDX_W'(10) - frame.sym_idx;
    addr_shifted = address >> addr_off;

    if (frame.sym_idx == '0) begin
      sym = SYM_START;
    end else if (frame.sym_idx >= last_idx) begin
      sym = SYM_STOP;
    end else if (frame.sym_idx <= ADDR_LAST) begin
      sym = addr_shifted[0] ? SYM_ONE : SYM_ZERO;
    end else if (frame.sym_idx == ADDR_LAST + SYM_IDX_W'(1)) begin
      sym = (frame.kind == MODE_GROUP) ? SYM_ONE : SYM_ZERO;
    end else if (frame.sym_idx == ADDR_LAST + SYM_IDX_W'(2)) begin
      if (frame.kind == MODE_DIM) begin
        sym = SYM_DIM;
      end else begin
        sym = frame.sw ? SYM_ONE : SYM_ZERO;
      end
    end else if (frame.sym_idx <= ADDR_LAST + SYM_IDX_W'(6)) begin
      sym = frame.unit[unit_off[1:0]] ? SYM_ONE : SYM_ZERO;
    end else begin
      sym = frame.dim[dim_off[1:0]] ? SYM_ONE : SYM_ZERO;
    end
  end

  // A period of zero behaves as one tick.
  always_comb begin
    t     = (period == '0) ? PERIOD_W'(1) : period;
    t_ext = SEG_LEN_W'(t);

    seg.sym      = sym;
    seg.last_sym = (frame.sym_idx >= last_idx);

    if ((sym == SYM_START) || (sym == SYM_STOP)) begin
      seg.last_seg = (frame.phase == 2'd1);
    end else begin
      seg.last_seg = (frame.phase == 2'd3);
    end

    if (!frame.phase[0]) begin
      seg.len = t_ext;
    end else begin
      case (sym)
        SYM_START: seg.len = t_ext * SEG_LEN_W'(10) + (t_ext >> 1);
        SYM_STOP:  seg.len = t_ext * SEG_LEN_W'(40);
        SYM_ONE:   seg.len = (frame.phase == 2'd1) ? t_ext * SEG_LEN_W'(5) : t_ext;
        SYM_ZERO:  seg.len = (frame.phase == 2'd3) ? t_ext * SEG_LEN_W'(5) : t_ext;
        default:   seg.len = t_ext;
      endcase
    end
  end

endmodule

// File: rtl/ookrs_seq_core.sv
module ookrs_seq_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [1:0]                          mode_in,
  input  logic                                switch_on,
  input  logic [3:0]                          unit_number,
  input  logic [3:0]                          dim_level,
  input  logic [ookrs_pkg::REP_EXP_W-1:0]     repeat_exp,
  input  ookrs_pkg::seg_info_t                seg,
  output ookrs_pkg::frame_state_t             frame,
  output logic                                active,
  output ookrs_pkg::result_t                  result
);
  import ookrs_pkg::*;

  frame_state_t         frame_r, frame_nxt;
  logic [SEG_LEN_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [REPEATS_W-1:0] repeats_r, repeats_nxt;
  logic                 active_r, active_nxt;
  mode_t                mode;
  logic                 is_tick;

  assign mode    = mode_t'(mode_in);
  assign is_tick = (mode == MODE_TICK);

  always_comb begin
    frame_nxt   = frame_r;
    tick_nxt    = tick_r;
    repeats_nxt = repeats_r;
    active_nxt  = active_r;
    tick_inc    = tick_r + SEG_LEN_W'(1);

    if (accept) begin
      if (is_tick) begin
        if (active_r) begin
          if (tick_inc < seg.len) begin
            tick_nxt = tick_inc;
          end else begin
            tick_nxt = '0;
            if (!seg.last_seg) begin
              frame_nxt.phase = frame_r.phase + 2'd1;
            end else begin
              frame_nxt.phase = '0;
              if (!seg.last_sym) begin
                frame_nxt.sym_idx = frame_r.sym_idx + SYM_IDX_W'(1);
              end else begin
                frame_nxt.sym_idx = '0;
                repeats_nxt = repeats_r - REPEATS_W'(1);
                if (repeats_r == REPEATS_W'(1)) begin
                  active_nxt = 1'b0;
                end
              end
            end
          end
        end
      end else if (!active_r) begin
        frame_nxt.kind    = mode;
        frame_nxt.sw      = (mode == MODE_DIM) ? 1'b0 : switch_on;
        frame_nxt.unit    = (mode == MODE_GROUP) ? 4'd0 : unit_number;
        frame_nxt.dim     = (mode == MODE_DIM) ? dim_level : 4'd0;
        frame_nxt.sym_idx = '0;
        frame_nxt.phase   = '0;
        tick_nxt          = '0;
        repeats_nxt       = REPEATS_W'(1) << repeat_exp;
        active_nxt        = 1'b1;
      end
    end
  end

  // Carrier level is high on even phases; a fresh command starts on a high segment.
  always_comb begin
    result.rf_on    = (is_tick || active_r) ? (active_r & ~frame_r.phase[0]) : 1'b1;
    result.busy_res = active_nxt;
    result.rejected = !is_tick && active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      tick_r    <= '0;
      repeats_r <= '0;
      active_r  <= 1'b0;
    end else begin
      frame_r   <= frame_nxt;
      tick_r    <= tick_nxt;
      repeats_r <= repeats_nxt;
      active_r  <= active_nxt;
    end
  end

  assign frame  = frame_r;
  assign active = active_r;

endmodule

// File: rtl/ook_remote_switch_pulse_encoder.sv
// On-off keyed pulse encoder for a self-learning remote switch. Every request on
// the input channel is either a one-microsecond tick or a group, unit or dim
// command, and every request yields exactly one result: the carrier level for
// that tick, whether a transmission is in progress, and whether a command was
// dropped because the block was busy. An accepted command is latched and its
// frame is sent 2^repeat_exponent times, timed purely by the tick requests. The
// block takes one request per clock cycle: the frame state update and the
// result are formed in a single pass of logic and the result is held in one
// output register, so in_ready stays high whenever that register is empty or
// is being emptied in the same cycle. Configuration writes are always taken
// and act at once; there is no start-up clearing sequence.
module ook_remote_switch_pulse_encoder #(
  parameter int ADDRESS_BITS = 26
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_mode,
  input  logic                                  in_switch_on,
  input  logic [3:0]                            in_unit_number,
  input  logic [3:0]                            in_dim_level,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_rf_on,
  output logic                                  out_busy_res,
  output logic                                  out_rejected,
  // Configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ookrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ookrs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ookrs_pkg::*;

  // Configuration registers.
  logic [ADDRESS_BITS-1:0] address_r, address_nxt;
  logic [PERIOD_W-1:0]     period_r, period_nxt;
  logic [REP_EXP_W-1:0]    repeat_r, repeat_nxt;
  logic [31:0]             cfg_addr_ext;

  // Output register.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic         in_accept;
  frame_state_t frame;
  seg_info_t    seg;
  result_t      result;
  logic         active;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // The address register is 26 bits wide on the bus and is cut to, or padded
  // out to, the configured address length.
  assign cfg_addr_ext = {{(32 - CFG_DATA_W){1'b0}}, cfg_wdata};

  always_comb begin
    address_nxt = address_r;
    period_nxt  = period_r;
    repeat_nxt  = repeat_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ADDRESS: address_nxt = cfg_addr_ext[ADDRESS_BITS-1:0];
        CFG_PERIOD:  period_nxt  = cfg_wdata[PERIOD_W-1:0];
        CFG_REPEAT:  repeat_nxt  = cfg_wdata[REP_EXP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      address_r <= '0;
      period_r  <= PERIOD_RESET;
      repeat_r  <= REPEAT_RESET;
    end else begin
      address_r <= address_nxt;
      period_r  <= period_nxt;
      repeat_r  <= repeat_nxt;
    end
  end

  ookrs_frame_decode #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_decode (
    .frame   (frame),
    .address (address_r),
    .period  (period_r),
    .seg     (seg)
  );

  ookrs_seq_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .mode_in     (in_mode),
    .switch_on   (in_switch_on),
    .unit_number (in_unit_number),
    .dim_level   (in_dim_level),
    .repeat_exp  (repeat_r),
    .seg         (seg),
    .frame       (frame),
    .active      (active),
    .result      (result)
  );

  // The result register fills on every accepted request and empties when the
  // consumer takes it; a request in the same cycle refills it directly.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rf_on    = out_res_r.rf_on;
  assign out_busy_res = out_res_r.busy_res;
  assign out_rejected = out_res_r.rejected;

`ifndef SYNTHESIS
  // A dropped command never changes the state, so the block is still busy.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rejected) |-> out_busy_res)
    else $error("rejected result without busy");

  // A command taken while idle starts a transmission on a high segment.
  a_cmd_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_mode != MODE_TICK) && !active)
    |=> (out_valid && out_rf_on && out_busy_res && !out_rejected && active))
    else $error("idle command did not start a transmission");

  // A transmission can only end on an accepted tick.
  a_end_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(active) && $past(rst_n)) |-> $past(in_accept && (in_mode == MODE_TICK)))
    else $error("transmission ended without a tick");

  // Every accepted request leaves a result waiting.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");
`endif

endmodule
